// ===== rtl/core/knapsack_01_solver_core_defines.svh =====
// Assertion helpers for the knapsack solver core
`ifndef KNAPSACK_01_SOLVER_CORE_DEFINES_SVH
`define KNAPSACK_01_SOLVER_CORE_DEFINES_SVH

// check outside reset
`define KS01_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also covers the reset cycles
`define KS01_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ks01_pkg.sv =====
package ks01_pkg;

  localparam int DEF_MAX_ITEMS    = 16;
  localparam int DEF_MAX_CAPACITY = 255;

  localparam int CAPREG_W = 8;
  localparam int WEIGHT_W = 8;
  localparam int PROFIT_W = 16;
  localparam int IDX_W    = 5;
  localparam int TOTAL_W  = 20;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL_LD,
    ST_FILL_CELL,
    ST_FILL_DRAIN,
    ST_TB_INIT,
    ST_TB_CHECK,
    ST_TB_EVAL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic fill_init;
    logic item_rd;
    logic col_init;
    logic fill_step;
    logic row_done;
    logic tb_init;
    logic tb_rd;
    logic tb_step;
    logic emit_init;
    logic emit_one;
  } cmd_t;

  typedef struct packed {
    logic cap_zero;
    logic c_one;
    logic row_last;
    logic tb_done;
    logic out_free;
    logic emit_last;
  } status_t;

endpackage

// ===== rtl/core/ks01_ctrl.sv =====
module ks01_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              is_last,
  output logic              in_ready,
  input  ks01_pkg::status_t status,
  output ks01_pkg::cmd_t    cmd
);
  import ks01_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_last) begin
          state_next = status.cap_zero ? ST_TB_INIT : ST_FILL_LD;
        end
      end
      ST_FILL_LD: begin
        state_next = ST_FILL_CELL;
      end
      ST_FILL_CELL: begin
        if (status.c_one) begin
          state_next = ST_FILL_DRAIN;
        end
      end
      ST_FILL_DRAIN: begin
        state_next = status.row_last ? ST_TB_INIT : ST_FILL_LD;
      end
      ST_TB_INIT: begin
        state_next = ST_TB_CHECK;
      end
      ST_TB_CHECK: begin
        state_next = status.tb_done ? ST_EMIT : ST_TB_EVAL;
      end
      ST_TB_EVAL: begin
        state_next = ST_TB_CHECK;
      end
      ST_EMIT: begin
        if (status.out_free && status.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load      = accept;
        cmd.fill_init = accept && is_last;
      end
      ST_FILL_LD: begin
        cmd.item_rd  = 1'b1;
        cmd.col_init = 1'b1;
      end
      ST_FILL_CELL: begin
        cmd.fill_step = 1'b1;
      end
      ST_FILL_DRAIN: begin
        cmd.row_done = 1'b1;
      end
      ST_TB_INIT: begin
        cmd.tb_init = 1'b1;
      end
      ST_TB_CHECK: begin
        cmd.emit_init = status.tb_done;
        cmd.tb_rd     = !status.tb_done;
      end
      ST_TB_EVAL: begin
        cmd.tb_step = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit_one = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/ks01_datapath.sv =====
module ks01_datapath #(
  parameter int MAX_ITEMS    = ks01_pkg::DEF_MAX_ITEMS,
  parameter int MAX_CAPACITY = ks01_pkg::DEF_MAX_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ks01_pkg::cmd_t                   cmd,
  output ks01_pkg::status_t                status,
  input  logic                             cfg_wr,
  input  logic [ks01_pkg::CAPREG_W-1:0]    cfg_data,
  input  logic [ks01_pkg::WEIGHT_W-1:0]    weight,
  input  logic [ks01_pkg::PROFIT_W-1:0]    profit,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [ks01_pkg::IDX_W-1:0]       item_index,
  output logic                             chosen,
  output logic [ks01_pkg::TOTAL_W-1:0]     total_profit,
  output logic                             last_result
);
  import ks01_pkg::*;

  localparam int KW  = $clog2(MAX_ITEMS + 1);
  localparam int IW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW  = $clog2(MAX_CAPACITY + 1);
  localparam int XW  = (CW > CAPREG_W) ? CW : CAPREG_W;
  localparam int VW  = PROFIT_W + $clog2(MAX_ITEMS);
  localparam int IMW = WEIGHT_W + PROFIT_W;

  logic [CAPREG_W-1:0] cap_reg;
  logic [KW-1:0]       count;
  logic [KW-1:0]       k;
  logic [CW-1:0]       c;
  logic [CW-1:0]       rem;
  logic [TOTAL_W-1:0]  tot;
  logic [MAX_ITEMS-1:0] pick;

  logic [IMW-1:0] item_mem [MAX_ITEMS];
  logic [IMW-1:0] item_q;
  logic [VW-1:0]  value_mem [2**CW];
  logic [VW-1:0]  rd_a;
  logic [VW-1:0]  rd_b;
  logic           take_mem [2**(IW+CW)];
  logic           take_q;

  logic          s1_valid;
  logic [CW-1:0] s1_c;
  logic          s1_fit;
  logic          s1_bzero;

  logic [XW-1:0]       cap_ext;
  logic [CW-1:0]       cap;
  logic [WEIGHT_W-1:0] wt_q;
  logic [PROFIT_W-1:0] pr_q;
  logic [XW-1:0]       c_ext;
  logic [XW-1:0]       wt_ext;
  logic                fit;
  logic [CW-1:0]       addr_b;
  logic                first_row;
  logic [VW-1:0]       skip_v;
  logic [VW-1:0]       base_b;
  logic [VW-1:0]       with_v;
  logic                take_c;
  logic [VW-1:0]       new_v;
  logic [KW-1:0]       km1;
  logic [IW-1:0]       km1_idx;
  logic [IW-1:0]       item_raddr;
  logic [KW:0]         k_inc;
  logic                emit_last;
  logic [TOTAL_W:0]    tot_sum;
  logic [TOTAL_W-1:0]  tot_sat;

  assign cap_ext = XW'(cap_reg);
  assign cap     = (cap_ext > XW'(MAX_CAPACITY)) ? CW'(MAX_CAPACITY) : CW'(cap_reg);
  assign wt_q    = item_q[IMW-1:PROFIT_W];
  assign pr_q    = item_q[PROFIT_W-1:0];

  assign c_ext  = XW'(c);
  assign wt_ext = XW'(wt_q);
  assign fit    = (c_ext >= wt_ext);
  assign addr_b = CW'(c_ext - wt_ext);

  assign first_row = (k == '0);
  assign skip_v    = first_row ? '0 : rd_a;
  assign base_b    = (first_row || s1_bzero) ? '0 : rd_b;
  assign with_v    = base_b + VW'(pr_q);
  assign take_c    = s1_fit && (with_v > skip_v);
  assign new_v     = take_c ? with_v : skip_v;

  assign km1        = k - KW'(1);
  assign km1_idx    = km1[IW-1:0];
  assign item_raddr = cmd.tb_rd ? km1_idx : k[IW-1:0];
  assign k_inc      = {1'b0, k} + (KW+1)'(1);
  assign emit_last  = (k_inc == {1'b0, count});

  assign tot_sum = {1'b0, tot} + (TOTAL_W+1)'(pr_q);
  assign tot_sat = tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];

  assign status.cap_zero  = (cap == '0);
  assign status.c_one     = (c == CW'(1));
  assign status.row_last  = ((k + KW'(1)) == count);
  assign status.tb_done   = (k == '0) || (rem == '0);
  assign status.out_free  = !out_valid || out_ready;
  assign status.emit_last = emit_last;

  // item store
  always_ff @(posedge clk) begin
    if (cmd.load && (count < KW'(MAX_ITEMS))) begin
      item_mem[count[IW-1:0]] <= {weight, profit};
    end
    if (cmd.item_rd || cmd.tb_rd) begin
      item_q <= item_mem[item_raddr];
    end
  end

  // value row: two reads per cell, write one stage later
  always_ff @(posedge clk) begin
    if (cmd.fill_step) begin
      rd_a <= value_mem[c];
      rd_b <= value_mem[addr_b];
    end
    if (s1_valid) begin
      value_mem[s1_c] <= new_v;
    end
  end

  // take bits
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      take_mem[{k[IW-1:0], s1_c}] <= take_c;
    end
    if (cmd.tb_rd) begin
      take_q <= take_mem[{km1_idx, rem}];
    end
  end

  always_ff @(posedge clk) begin
    s1_c     <= c;
    s1_fit   <= fit;
    s1_bzero <= (c_ext == wt_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg   <= '0;
      count     <= '0;
      k         <= '0;
      c         <= '0;
      rem       <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        cap_reg <= cfg_data;
      end
      s1_valid <= cmd.fill_step;

      priority if (cmd.load) begin
        if (count < KW'(MAX_ITEMS)) begin
          count <= count + KW'(1);
        end
      end else if (cmd.emit_one && emit_last) begin
        count <= '0;
      end else begin
        count <= count;
      end

      priority if (cmd.fill_init || cmd.emit_init) begin
        k <= '0;
      end else if (cmd.row_done || cmd.emit_one) begin
        k <= k + KW'(1);
      end else if (cmd.tb_init) begin
        k <= count;
      end else if (cmd.tb_step) begin
        k <= km1;
      end else begin
        k <= k;
      end

      priority if (cmd.col_init) begin
        c <= cap;
      end else if (cmd.fill_step) begin
        c <= c - CW'(1);
      end else begin
        c <= c;
      end

      priority if (cmd.tb_init) begin
        rem <= cap;
      end else if (cmd.tb_step && take_q) begin
        rem <= CW'(XW'(rem) - wt_ext);
      end else begin
        rem <= rem;
      end

      priority if (cmd.emit_one) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end else begin
        out_valid <= out_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tb_init) begin
      tot  <= '0;
      pick <= '0;
    end else if (cmd.tb_step && take_q) begin
      tot           <= tot_sat;
      pick[km1_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_one) begin
      item_index   <= IDX_W'(k_inc);
      chosen       <= pick[k[IW-1:0]];
      total_profit <= emit_last ? tot : '0;
      last_result  <= emit_last;
    end
  end

endmodule

// ===== rtl/core/knapsack_01_solver_core.sv =====
// 0/1 knapsack solver core.
// Configuration: cfg_valid/cfg_ready carries the capacity; cfg_ready is always
// high. Write it only while the core is idle; values above MAX_CAPACITY clamp.
// Input: in_valid/in_ready carries weight, profit and is_last. Items load one
// per cycle while idle; items past MAX_ITEMS are dropped. An item with is_last
// starts the solve and in_ready stays low until the last result is loaded.
// Solve phases for n items and clamped capacity C:
//   fill      one row of C cells per item (skipped when C is zero), one table cell per
//             cycle through the dual-read value row memory;
//   traceback visits items from the last down, stopping once rem is zero;
//   results   one per cycle into the output register unless stalled.
// Output: out_valid/out_ready carries one item per loaded item, in index
// order, with total_profit on the result flagged last_result (zero elsewhere).
// A stalled receiver holds the output register and pauses result generation;
// the final result may wait while the next input items are already loading.
// Reset: synchronous; capacity returns to zero, the item store empties and
// the core comes up idle with no result pending. No clearing pass is needed.
module knapsack_01_solver_core #(
  parameter int MAX_ITEMS    = ks01_pkg::DEF_MAX_ITEMS,
  parameter int MAX_CAPACITY = ks01_pkg::DEF_MAX_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ks01_pkg::CAPREG_W-1:0] capacity,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ks01_pkg::WEIGHT_W-1:0] weight,
  input  logic [ks01_pkg::PROFIT_W-1:0] profit,
  input  logic                          is_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ks01_pkg::IDX_W-1:0]    item_index,
  output logic                          chosen,
  output logic [ks01_pkg::TOTAL_W-1:0]  total_profit,
  output logic                          last_result
);
  import ks01_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  ks01_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .is_last  (is_last),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ks01_datapath #(
    .MAX_ITEMS    (MAX_ITEMS),
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_wr       (cfg_valid && cfg_ready),
    .cfg_data     (capacity),
    .weight       (weight),
    .profit       (profit),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .item_index   (item_index),
    .chosen       (chosen),
    .total_profit (total_profit),
    .last_result  (last_result)
  );

`include "knapsack_01_solver_core_defines.svh"

  `KS01_ASSERT(a_total_only_last, out_valid && !last_result |-> total_profit == '0, "total early")
  `KS01_ASSERT(a_busy_after_last, in_valid && in_ready && is_last |=> !in_ready, "open in solve")
  `KS01_ASSERT(a_result_while_busy, $rose(out_valid) |-> !$past(in_ready), "result when idle")
  `KS01_ASSERT_RST(a_reset_idle, rst |=> in_ready && !out_valid, "not idle after reset")

endmodule
